// ----- hw/rtl/mfib_pkg.sv -----
// Shared constants and types for the meta-Fibonacci sequence generator.
`timescale 1ns / 1ps

package mfib_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 65536;

   localparam int INDEX_WIDTH    = 16;
   localparam int TERM_WIDTH     = 16;
   localparam int SELECT_WIDTH   = 2;
   localparam int STATUS_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 2;

   // Indices 0 to 2 always hold the seed value.
   localparam int                    SEED_COUNT = 3;
   localparam logic [TERM_WIDTH-1:0] SEED_VALUE = 16'd1;
   localparam logic [TERM_WIDTH-1:0] TERM_MAX   = 16'hFFFF;

   // Sequence selection codes.
   localparam logic [SELECT_WIDTH-1:0] SEL_Q         = 2'd0;
   localparam logic [SELECT_WIDTH-1:0] SEL_CONWAY    = 2'd1;
   localparam logic [SELECT_WIDTH-1:0] SEL_VARIANT_B = 2'd2;

   // Byte address of the selection register.
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SELECT_ADDR = 2'd0;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK            = 2'd0,
      STATUS_BEYOND_DEPTH  = 2'd1,
      STATUS_BAD_REFERENCE = 2'd2
   } status_type;

endpackage

// ----- hw/rtl/meta_fibonacci_sequence_generator_top.sv -----
// Top level of the meta-Fibonacci sequence generator: control, term memory and register port.
`timescale 1ns / 1ps
// A query beyond the table depth strobes its word in the cycle after acceptance; a query
// at or below the highest computed index is answered after one memory read and ST_ANSWER.
// Each new term passes through ST_STEP (read a(x)), ST_FETCH_Y (read a(y)) and ST_ADD (add
// and write back), all through the single read port; a query that extends the table repeats
// them for each new term, and a bad reference is answered from ST_STEP of the failing term.
// One query at a time, results cannot be stalled; reset selects Q and keeps only the seeds.

module meta_fibonacci_sequence_generator_top #(
   parameter int TABLE_DEPTH = mfib_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Query channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic [mfib_pkg::INDEX_WIDTH-1:0]       req_query_index,
   // Result channel
   output logic                                   rsp_valid,
   output logic [mfib_pkg::TERM_WIDTH-1:0]        rsp_term_value,
   output logic [mfib_pkg::STATUS_WIDTH-1:0]      rsp_status,
   // Register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [mfib_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [mfib_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [mfib_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                   pready
);

   // Address width of the term memory. Compare arithmetic is one bit wider than the wider of
   // the address and the term width, so that differences and the depth itself fit.
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = ((AW > mfib_pkg::TERM_WIDTH) ? AW : mfib_pkg::TERM_WIDTH) + 1;
   localparam int TW = mfib_pkg::TERM_WIDTH;

   localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);
   localparam logic [AW-1:0] SEED_LAST = AW'(mfib_pkg::SEED_COUNT - 1);
   localparam logic [AW-1:0] SEED_NUM  = AW'(mfib_pkg::SEED_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_FETCH_Y,
      ST_ADD,
      ST_ANSWER
   } state_type;

   // Control and registered outputs.
   state_type                           state_ff,      state_in;
   logic [mfib_pkg::SELECT_WIDTH-1:0]   select_ff,     select_in;
   logic [AW-1:0]                       filled_ff,     filled_in;
   logic [TW-1:0]                       prev1_ff,      prev1_in;
   logic [TW-1:0]                       prev2_ff,      prev2_in;
   logic [AW-1:0]                       query_ff,      query_in;
   logic [AW-1:0]                       y_index_ff,    y_index_in;
   logic [TW-1:0]                       x_value_ff,    x_value_in;
   logic                                rsp_valid_ff,  rsp_valid_in;
   logic [TW-1:0]                       rsp_value_ff,  rsp_value_in;
   mfib_pkg::status_type                rsp_status_ff, rsp_status_in;

   // Term memory: one write port, one registered read port.
   logic [TW-1:0] term_mem [TABLE_DEPTH];
   logic [TW-1:0] rd_data_ff;
   logic          rd_seed_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   logic [TW-1:0] mem_data;

   // Term arithmetic.
   logic [AW-1:0]   term_index;
   logic [CW-1:0]   i_c, p1_c, p2_c, x_c, y_c;
   logic            refs_ok;
   logic [TW:0]     sum_wide;
   logic [TW-1:0]   sum_sat;
   logic            csr_write;

   assign csr_write = psel && penable && pwrite && (paddr == mfib_pkg::CSR_SELECT_ADDR);

   // The seeds are never stored: a read of index 0 to 2 is replaced by the seed value.
   assign mem_data = rd_seed_ff ? mfib_pkg::SEED_VALUE : rd_data_ff;

   // The term being built is always the one just above the highest computed index.
   assign term_index = filled_ff + AW'(1);

   // Both back references of the new term come from the two previous terms, which sit in
   // registers, so only a(x) and a(y) need the memory.
   always_comb begin
      i_c     = CW'(term_index);
      p1_c    = CW'(prev1_ff);
      p2_c    = CW'(prev2_ff);
      refs_ok = 1'b0;
      x_c     = '0;
      y_c     = '0;
      unique case (select_ff)
         mfib_pkg::SEL_Q: begin
            refs_ok = (p1_c != '0) && (p1_c <= i_c) && (p2_c != '0) && (p2_c <= i_c);
            x_c     = i_c - p1_c;
            y_c     = i_c - p2_c;
         end
         mfib_pkg::SEL_CONWAY: begin
            refs_ok = (p1_c != '0) && (p1_c < i_c);
            x_c     = p1_c;
            y_c     = i_c - p1_c;
         end
         mfib_pkg::SEL_VARIANT_B: begin
            refs_ok = (p1_c < i_c) && (p2_c < i_c);
            x_c     = p1_c;
            y_c     = i_c - p2_c - CW'(1);
         end
         default: begin
            refs_ok = 1'b0;
         end
      endcase
      refs_ok = refs_ok && (x_c < i_c) && (y_c < i_c);
   end

   // Saturating sum of a(x) and a(y).
   assign sum_wide = {1'b0, x_value_ff} + {1'b0, mem_data};
   assign sum_sat  = sum_wide[TW] ? mfib_pkg::TERM_MAX : sum_wide[TW-1:0];

   // Read address: the query itself while idle, then a(x) and a(y) while a term is built.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:    rd_addr = AW'(req_query_index);
         ST_STEP:    rd_addr = x_c[AW-1:0];
         ST_FETCH_Y: rd_addr = y_index_ff;
         default:    rd_addr = query_ff;
      endcase
   end

   assign mem_we = (state_ff == ST_ADD);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         term_mem[term_index] <= sum_sat;
      end
      rd_data_ff <= term_mem[rd_addr];
      rd_seed_ff <= (rd_addr < SEED_NUM);
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in      = state_ff;
      select_in     = select_ff;
      filled_in     = filled_ff;
      prev1_in      = prev1_ff;
      prev2_in      = prev2_ff;
      query_in      = query_ff;
      y_index_in    = y_index_ff;
      x_value_in    = x_value_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (CW'(req_query_index) >= DEPTH_C) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = mfib_pkg::STATUS_BEYOND_DEPTH;
               end else begin
                  query_in = AW'(req_query_index);
                  if (AW'(req_query_index) <= filled_ff) begin
                     state_in = ST_ANSWER;
                  end else begin
                     state_in = ST_STEP;
                  end
               end
            end
         end
         ST_STEP: begin
            if (refs_ok) begin
               y_index_in = y_c[AW-1:0];
               state_in   = ST_FETCH_Y;
            end else begin
               // Generation stops at the last good term.
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = mfib_pkg::STATUS_BAD_REFERENCE;
               state_in      = ST_IDLE;
            end
         end
         ST_FETCH_Y: begin
            x_value_in = mem_data;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            filled_in = term_index;
            prev2_in  = prev1_ff;
            prev1_in  = sum_sat;
            if (term_index == query_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = sum_sat;
               rsp_status_in = mfib_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_ANSWER: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = mem_data;
            rsp_status_in = mfib_pkg::STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new selection restarts generation from the seeds.
      if (csr_write) begin
         select_in = pwdata[mfib_pkg::SELECT_WIDTH-1:0];
         filled_in = SEED_LAST;
         prev1_in  = mfib_pkg::SEED_VALUE;
         prev2_in  = mfib_pkg::SEED_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         select_ff    <= mfib_pkg::SEL_Q;
         filled_ff    <= SEED_LAST;
         prev1_ff     <= mfib_pkg::SEED_VALUE;
         prev2_ff     <= mfib_pkg::SEED_VALUE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         select_ff    <= select_in;
         filled_ff    <= filled_in;
         prev1_ff     <= prev1_in;
         prev2_ff     <= prev2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      query_ff      <= query_in;
      y_index_ff    <= y_index_in;
      x_value_ff    <= x_value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_term_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   // Register reads: only the selection register answers, other offsets read as zero.
   assign prdata = (paddr == mfib_pkg::CSR_SELECT_ADDR) ?
                   mfib_pkg::CSR_DATA_WIDTH'(select_ff) : '0;
   assign pready = 1'b1;

endmodule

// ----- hw/rtl/mfib_checker.sv -----
// Port-level checker for the meta-Fibonacci sequence generator and its bind.
`timescale 1ns / 1ps

module mfib_checker #(
   parameter int TABLE_DEPTH = mfib_pkg::TABLE_DEPTH_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [mfib_pkg::INDEX_WIDTH-1:0]    req_query_index,
   input logic                                rsp_valid,
   input logic [mfib_pkg::TERM_WIDTH-1:0]     rsp_term_value,
   input logic [mfib_pkg::STATUS_WIDTH-1:0]   rsp_status
);

   localparam int CW = mfib_pkg::INDEX_WIDTH + 2;
   localparam logic [CW-1:0] DEPTH_C = (TABLE_DEPTH > 65536) ? {CW{1'b1}} : CW'(TABLE_DEPTH);

   // A failed query always reports a zero term.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != mfib_pkg::STATUS_OK)) |-> (rsp_term_value == '0))
      else $error("error word carries a non-zero term");

   // A query beyond the depth is refused in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (CW'(req_query_index) >= DEPTH_C)) |=>
      (rsp_valid && (rsp_status == mfib_pkg::STATUS_BEYOND_DEPTH)))
      else $error("query beyond depth not refused in time");

   // The seeds are always available and are answered with the seed value, not read from the table.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_query_index < 16'd3)) |-> ##2
      (rsp_valid && (rsp_term_value == mfib_pkg::SEED_VALUE) &&
       (rsp_status == mfib_pkg::STATUS_OK)))
      else $error("seed query answered wrongly");

   // Every query that keeps the block busy ends with a result word when busy drops.
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result word");

endmodule

bind meta_fibonacci_sequence_generator_top mfib_checker #(
   .TABLE_DEPTH(TABLE_DEPTH)
) u_mfib_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_query_index(req_query_index),
   .rsp_valid      (rsp_valid),
   .rsp_term_value (rsp_term_value),
   .rsp_status     (rsp_status)
);

// ----- test/tb_meta_fibonacci_sequence_generator_top.sv -----
// Self-checking testbench for the meta-Fibonacci sequence generator top level.
`timescale 1ns / 1ps

module tb_meta_fibonacci_sequence_generator_top;

   // The block is built with its default table depth, which covers the whole index
   // range, so every query is answered from the table or ends on a bad reference.
   localparam int TBL_DEPTH         = mfib_pkg::TABLE_DEPTH_DEFAULT;
   localparam int QUIET_LIMIT       = 800000;
   localparam int RANDOM_PHASES     = 10;
   localparam int QUERIES_PER_PHASE = 125;
   localparam int MAX_GAP           = 17;
   localparam int SETTLE_CYCLES     = 16;

   typedef logic [mfib_pkg::TERM_WIDTH-1:0]     term_type;
   typedef logic [mfib_pkg::INDEX_WIDTH-1:0]    index_type;
   typedef logic [mfib_pkg::CSR_DATA_WIDTH-1:0] csr_word_type;

   typedef struct packed {
      term_type             term_value;
      mfib_pkg::status_type status;
   } term_answer_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   index_type    req_query_index;
   logic         rsp_valid;
   term_type     rsp_term_value;
   logic [mfib_pkg::STATUS_WIDTH-1:0] rsp_status;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [mfib_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   csr_word_type pwdata;
   csr_word_type prdata;
   logic         pready;

   // Our own copy of the term table, the highest computed index and the selection.
   term_type                          term_mem [TBL_DEPTH];
   int                                filled_index;
   logic [mfib_pkg::SELECT_WIDTH-1:0] model_select;

   // Answers still owed by the block, oldest first.
   term_answer_type expected_answers [$];
   term_answer_type oldest_answer;
   int              error_count;
   int              quiet_cycles;
   // When set, the sender puts every query straight after the previous one.
   bit              no_idle;

   meta_fibonacci_sequence_generator_top #(
      .TABLE_DEPTH (TBL_DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_query_index (req_query_index),
      .rsp_valid       (rsp_valid),
      .rsp_term_value  (rsp_term_value),
      .rsp_status      (rsp_status),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Computes term i from the terms below it. Returns 0 when the recurrence would
   // reach an index that is negative or not yet computed; the table is then untouched.
   function automatic bit grow_term(int i);
      int p1;
      int p2;
      int x;
      int y;
      int sum;
      p1 = term_mem[i-1];
      p2 = term_mem[i-2];
      case (model_select)
         mfib_pkg::SEL_Q: begin
            if (p1 < 1 || p1 > i || p2 < 1 || p2 > i) return 1'b0;
            x = i - p1;
            y = i - p2;
         end
         mfib_pkg::SEL_CONWAY: begin
            if (p1 < 1 || p1 >= i) return 1'b0;
            x = p1;
            y = i - p1;
         end
         mfib_pkg::SEL_VARIANT_B: begin
            if (p1 >= i || p2 + 1 > i) return 1'b0;
            x = p1;
            y = i - p2 - 1;
         end
         default: begin
            // The fourth selection code has no recurrence at all.
            return 1'b0;
         end
      endcase
      if (x >= i || y >= i) return 1'b0;
      sum = int'(term_mem[x]) + int'(term_mem[y]);
      if (sum > int'(mfib_pkg::TERM_MAX)) sum = int'(mfib_pkg::TERM_MAX);
      term_mem[i] = term_type'(sum);
      return 1'b1;
   endfunction

   // Extends our table up to the queried index and works out the word the block owes.
   function automatic term_answer_type answer_query(index_type q);
      term_answer_type answer;
      int              qi;
      qi = int'(q);
      answer.term_value = '0;
      answer.status     = mfib_pkg::STATUS_BEYOND_DEPTH;
      if (qi >= TBL_DEPTH) return answer;
      while (filled_index < qi) begin
         if (!grow_term(filled_index + 1)) begin
            // Generation stops at the last good index; the next query retries.
            answer.status = mfib_pkg::STATUS_BAD_REFERENCE;
            return answer;
         end
         filled_index++;
      end
      answer.term_value = term_mem[qi];
      answer.status     = mfib_pkg::STATUS_OK;
      return answer;
   endfunction

   // Most random queries stay close to the computed part of the table, so that each
   // one extends it by a handful of terms. The rest are spread over the whole index
   // range or hit its edges and its middle.
   function automatic index_type pick_query_index();
      int roll;
      int top;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         top = filled_index + 80;
         if (top > TBL_DEPTH - 1) top = TBL_DEPTH - 1;
         return index_type'($urandom_range(0, top));
      end
      if (roll < 85) return index_type'($urandom());
      case ($urandom_range(0, 3))
         0: return '0;
         1: return index_type'(TBL_DEPTH - 1);
         2: return index_type'(TBL_DEPTH / 2);
         default: return '1;
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Every word on the result channel is compared with the oldest answer owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("word with no query outstanding", rsp_term_value, -1);
         end else begin
            oldest_answer = expected_answers.pop_front();
            if (rsp_term_value !== oldest_answer.term_value)
               report_mismatch("term value", rsp_term_value, oldest_answer.term_value);
            if (rsp_status !== oldest_answer.status)
               report_mismatch("status", rsp_status, oldest_answer.status);
         end
      end
   end

   // The run is abandoned when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("[meta_fibonacci_sequence_generator_top] ERROR");
            $finish;
         end
      end
   end

   // Sends one query after a random pause (none when no_idle is set). Control returns at the
   // edge that accepted it, without touching start, so that a following query may keep start high.
   task automatic send_query(index_type idx);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_query_index <= idx;
      do @(posedge clock); while (busy);
      expected_answers.push_back(answer_query(idx));
   endtask

   // Stops sending and waits until every owed word has come and the block is idle.
   task automatic finish_queries();
      start <= 1'b0;
      while (expected_answers.size() != 0 || busy) @(posedge clock);
   endtask

   // One register transfer: a setup phase, an access phase, then an idle phase.
   task automatic csr_access(bit is_write, csr_word_type wdata, output csr_word_type rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= mfib_pkg::CSR_SELECT_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_select(logic [mfib_pkg::SELECT_WIDTH-1:0] want);
      csr_word_type readback;
      csr_access(1'b0, '0, readback);
      if (readback[mfib_pkg::SELECT_WIDTH-1:0] !== want)
         report_mismatch("selection readback", readback[mfib_pkg::SELECT_WIDTH-1:0], want);
   endtask

   // Writing the selection restarts generation from the seeds, in the block and here.
   task automatic write_select(csr_word_type value);
      csr_word_type unused;
      finish_queries();
      csr_access(1'b1, value, unused);
      model_select = value[mfib_pkg::SELECT_WIDTH-1:0];
      filled_index = mfib_pkg::SEED_COUNT - 1;
      check_select(value[mfib_pkg::SELECT_WIDTH-1:0]);
   endtask

   // After reset the selection is Hofstadter Q and only the seeds are known.
   task automatic test_reset_state();
      check_select(mfib_pkg::SEL_Q);
      send_query(16'd0);
      send_query(16'd1);
      send_query(16'd2);
   endtask

   // The first computed term, the whole table in one go, index zero straight after it,
   // the top of the index range and terms that are already in the table.
   task automatic test_index_extremes();
      send_query(16'd3);
      send_query(index_type'(TBL_DEPTH - 1));
      send_query(16'd0);
      send_query(16'hFFFF);
      send_query(16'h8000);
      send_query(16'd100);
   endtask

   task automatic test_each_sequence();
      logic [mfib_pkg::SELECT_WIDTH-1:0] codes [3];
      codes = '{mfib_pkg::SEL_Q, mfib_pkg::SEL_CONWAY, mfib_pkg::SEL_VARIANT_B};
      foreach (codes[k]) begin
         write_select(csr_word_type'(codes[k]));
         send_query(16'd10);
         send_query(16'd5);
         send_query(16'd64);
      end
   endtask

   // The fourth code has no recurrence: seeds answer, everything above is a bad
   // reference. All write data bits are high here.
   task automatic test_select_three();
      write_select('1);
      send_query(16'd2);
      send_query(16'd3);
      send_query(16'd100);
      send_query(16'd1);
   endtask

   // Rewriting the same selection must throw away the terms computed so far.
   task automatic test_restart();
      write_select(csr_word_type'(mfib_pkg::SEL_CONWAY));
      send_query(16'd200);
      write_select(csr_word_type'(mfib_pkg::SEL_CONWAY));
      send_query(16'd150);
   endtask

   // Phases of random queries, each under a selection that cycles through all four codes, with
   // random upper data bits; every third phase runs without any pause between queries.
   task automatic test_random_queries();
      csr_word_type value;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         value = $urandom();
         value[mfib_pkg::SELECT_WIDTH-1:0] = mfib_pkg::SELECT_WIDTH'(phase % 4);
         write_select(value);
         no_idle = (phase % 3 == 2);
         repeat (QUERIES_PER_PHASE) send_query(pick_query_index());
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_query_index = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = mfib_pkg::CSR_SELECT_ADDR;
      pwdata          = '0;
      error_count     = 0;
      quiet_cycles    = 0;
      no_idle         = 1'b0;
      for (int k = 0; k < mfib_pkg::SEED_COUNT; k++) term_mem[k] = mfib_pkg::SEED_VALUE;
      filled_index = mfib_pkg::SEED_COUNT - 1;
      model_select = mfib_pkg::SEL_Q;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_index_extremes();
      test_each_sequence();
      test_select_three();
      test_restart();
      test_random_queries();

      // Any stray word arriving after the last answer is reported as a word with no query outstanding.
      finish_queries();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("[meta_fibonacci_sequence_generator_top] OK");
      end else begin
         $display("[meta_fibonacci_sequence_generator_top] ERROR");
      end
      $finish;
   end

endmodule
